>>> hw/rtl/rlpbe_pkg.sv
// ----------------------------------------------------------------------------
// RGB LED PWM bit encoder package
// Shared types, codes and defaults of the encoder blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package rlpbe_pkg;

    localparam int DEF_COLS       = 8;
    localparam int DEF_ROWS       = 8;
    localparam int BURST_LEN      = 24;
    localparam int BIT_W          = 5;
    localparam int COUNT_W        = 7;
    localparam int CFG_DATA_W     = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int Q_DEPTH        = 2;
    localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);

    localparam logic [COUNT_W-1:0] RST_ONE_BIT_COUNT  = 7'd85;
    localparam logic [COUNT_W-1:0] RST_ZERO_BIT_COUNT = 7'd40;
    localparam logic [7:0]         RST_RESET_BURSTS   = 8'd10;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_REFILL = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ONE_BIT_COUNT  = 2'd0,
        CFG_ZERO_BIT_COUNT = 2'd1,
        CFG_RESET_BURSTS   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_opcode    opcode;
        logic [2:0] pixel_col;
        logic [2:0] pixel_row;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] duty_count;
        logic               burst_last;
    } t_out_item;

    typedef struct packed {
        logic [COUNT_W-1:0] one_bit_count;
        logic [COUNT_W-1:0] zero_bit_count;
        logic [7:0]         reset_bursts;
    } t_cfg;

    typedef struct packed {
        logic        data_phase;
        logic [23:0] grb;
    } t_q_entry;

    typedef struct packed {
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_status;

endpackage

`default_nettype wire

>>> hw/rtl/rlpbe_if.sv
// ----------------------------------------------------------------------------
// RGB LED PWM bit encoder channels
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlpbe_in_if import rlpbe_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rlpbe_out_if import rlpbe_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rlpbe_front.sv
// ----------------------------------------------------------------------------
// RGB LED PWM bit encoder front end
// Accepts transactions, keeps the frame store and the frame phase, and
// queues one entry per refill request.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpbe_front import rlpbe_pkg::*; #(
    parameter int COLS = DEF_COLS,
    parameter int ROWS = DEF_ROWS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rlpbe_in_if.sink    i_in,
    input  t_cfg        i_cfg,
    input  t_q_status   i_q_status,
    output logic        o_push,
    output t_q_entry    o_entry
);

    localparam int NPIX   = COLS * ROWS;
    localparam int ADDR_W = (NPIX > 1) ? $clog2(NPIX) : 1;

    logic [23:0]       mem [NPIX];
    logic              r_clr;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_in_data;
    logic [7:0]        r_rst_cnt;
    logic [7:0]        n_rst_cnt;
    logic [ADDR_W-1:0] r_pix;
    logic              r_rd_valid;
    logic              r_rd_phase;
    logic [23:0]       r_rd_data;

    logic              room;
    logic              accept;
    logic              refill;
    logic              in_bounds;
    logic              wr_en;
    logic [12:0]       wr_addr_full;
    logic [ADDR_W-1:0] wr_addr;

    assign room = ({1'b0, i_q_status.count} + (Q_CNT_W + 1)'(r_rd_valid))
                  < (Q_CNT_W + 1)'(Q_DEPTH);
    assign i_in.ready = !r_clr && room;
    assign accept     = i_in.valid && i_in.ready;
    assign refill     = accept && (i_in.data.opcode == OP_REFILL);

    assign in_bounds    = ({4'b0, i_in.data.pixel_col} < 7'(COLS))
                       && ({4'b0, i_in.data.pixel_row} < 7'(ROWS));
    assign wr_en        = accept && (i_in.data.opcode == OP_WRITE) && in_bounds;
    assign wr_addr_full = 13'(i_in.data.pixel_row) * 13'(COLS) + 13'(i_in.data.pixel_col);
    assign wr_addr      = wr_addr_full[ADDR_W-1:0];

    assign n_rst_cnt = (r_rst_cnt != 8'hFF) ? r_rst_cnt + 8'd1 : r_rst_cnt;

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            mem[r_clr_addr] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= {i_in.data.green_level, i_in.data.red_level,
                             i_in.data.blue_level};
        end
        if (refill) begin
            r_rd_data <= mem[r_pix];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_in_data  <= 1'b0;
            r_rst_cnt  <= '0;
            r_pix      <= '0;
            r_rd_valid <= 1'b0;
            r_rd_phase <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(NPIX - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            r_rd_valid <= refill;
            if (refill) begin
                r_rd_phase <= r_in_data;
                if (!r_in_data) begin
                    r_rst_cnt <= n_rst_cnt;
                    if (n_rst_cnt >= i_cfg.reset_bursts) begin
                        r_in_data <= 1'b1;
                        r_pix     <= '0;
                    end
                end else if (r_pix == ADDR_W'(NPIX - 1)) begin
                    r_pix     <= '0;
                    r_rst_cnt <= '0;
                    r_in_data <= 1'b0;
                end else begin
                    r_pix <= r_pix + ADDR_W'(1);
                end
            end
        end
    end

    assign o_push  = r_rd_valid;
    assign o_entry = '{data_phase: r_rd_phase, grb: r_rd_data};

endmodule

`default_nettype wire

>>> hw/rtl/rlpbe_queue.sv
// ----------------------------------------------------------------------------
// RGB LED PWM bit encoder queue
// Short first-in first-out queue of burst entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpbe_queue import rlpbe_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push,
    input  t_q_entry   i_entry,
    input  wire        i_pop,
    output t_q_entry   o_head,
    output t_q_status  o_status
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    t_q_entry           r_slot [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    assign o_head         = r_slot[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

endmodule

`default_nettype wire

>>> hw/rtl/rlpbe_back.sv
// ----------------------------------------------------------------------------
// RGB LED PWM bit encoder back end
// Turns each queued entry into a burst of compare counts, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpbe_back import rlpbe_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_q_entry    i_head,
    input  t_q_status   i_q_status,
    input  t_cfg        i_cfg,
    output logic        o_pop,
    rlpbe_out_if.source o_out
);

    logic             r_busy;
    logic             r_phase;
    logic [23:0]      r_grb;
    logic [BIT_W-1:0] r_bit;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             advance;
    logic             have;
    logic             cur_phase;
    logic [23:0]      cur_grb;
    logic [BIT_W-1:0] cur_bit;
    logic             cur_last;
    logic [COUNT_W-1:0] cur_duty;

    assign advance   = !r_out_valid || o_out.ready;
    assign have      = r_busy || !i_q_status.empty;
    assign cur_phase = r_busy ? r_phase : i_head.data_phase;
    assign cur_grb   = r_busy ? r_grb : i_head.grb;
    assign cur_bit   = r_busy ? r_bit : '0;
    assign cur_last  = (cur_bit == BIT_W'(BURST_LEN - 1));
    assign cur_duty  = !cur_phase ? '0 :
                       (cur_grb[23] ? i_cfg.one_bit_count : i_cfg.zero_bit_count);
    assign o_pop     = advance && !r_busy && !i_q_status.empty;

    always_ff @(posedge i_clk) begin
        if (advance && have) begin
            r_out.duty_count <= cur_duty;
            r_out.burst_last <= cur_last;
            r_grb            <= {cur_grb[22:0], 1'b0};
            r_bit            <= cur_bit + BIT_W'(1);
            r_phase          <= cur_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= have;
            if (have) begin
                r_busy <= !cur_last;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

`default_nettype wire

>>> hw/rtl/rgb_led_pwm_bit_encoder.sv
// ----------------------------------------------------------------------------
// RGB LED PWM bit encoder
// A refill request is read from the frame store into the front-end read
// register, queued, then turned into a burst of 24 counts, one per cycle while
// the output is not stalled. Refill requests are accepted while the queue has
// room, so their rate is set by the output stage; pixel writes are accepted
// every cycle while queue room lasts. Reset is synchronous; after it the frame
// store is cleared pixel by pixel, with no transaction but configuration writes taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_pwm_bit_encoder import rlpbe_pkg::*; #(
    parameter int COLS = DEF_COLS,
    parameter int ROWS = DEF_ROWS
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    rlpbe_in_if.sink                  i_in,
    rlpbe_out_if.source               o_out,
    input  wire                       i_cfg_we,
    input  wire [CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]      i_cfg_data
);

    t_cfg      r_cfg;
    logic      push;
    logic      pop;
    t_q_entry  push_entry;
    t_q_entry  head;
    t_q_status q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_bit_count  <= RST_ONE_BIT_COUNT;
            r_cfg.zero_bit_count <= RST_ZERO_BIT_COUNT;
            r_cfg.reset_bursts   <= RST_RESET_BURSTS;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ONE_BIT_COUNT: begin
                    r_cfg.one_bit_count <= i_cfg_data[COUNT_W-1:0];
                end
                CFG_ZERO_BIT_COUNT: begin
                    r_cfg.zero_bit_count <= i_cfg_data[COUNT_W-1:0];
                end
                CFG_RESET_BURSTS: begin
                    r_cfg.reset_bursts <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    rlpbe_front #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (r_cfg),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    rlpbe_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    rlpbe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .i_cfg      (r_cfg),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire
